[rtl/core/kdl_pkg.sv]
// Shared types and constants for the keyed deque lookup block.
// Used by kdl_cell and keyed_deque_lookup; depends on nothing else.
`default_nettype none

package kdl_pkg;

	localparam int DEPTH = 64;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int COUNT_OUT_W = 7;

	localparam logic [1:0] CMD_APPEND = 2'd0;
	localparam logic [1:0] CMD_PREPEND = 2'd1;
	localparam logic [1:0] CMD_LOOKUP = 2'd2;

	localparam logic signed [15:0] NOT_FOUND_HEIGHT = -16'sd256;

	typedef struct packed {
		logic [1:0] cmd;
		logic [4:0] day;
		logic [3:0] month;
		logic [11:0] year;
		logic [4:0] hour;
		logic signed [15:0] height_in;
	} req_t;

	typedef struct packed {
		logic found;
		logic signed [15:0] height_out;
		logic [COUNT_OUT_W-1:0] entry_count;
		logic overflow;
	} rsp_t;

	typedef struct packed {
		logic [4:0] day;
		logic [3:0] month;
		logic [11:0] year;
		logic [4:0] hour;
		logic signed [15:0] height;
	} rec_t;

	// Per-cell control: load takes the new record, push moves the row one
	// place toward the back, rotate moves it one place toward the front.
	typedef struct packed {
		logic load;
		logic push;
		logic rotate;
	} cell_ctrl_t;

endpackage

`default_nettype wire

[rtl/core/kdl_cell.sv]
// One storage cell of the record row.
// Depends on kdl_pkg for the record and control types.
`default_nettype none

module kdl_cell (
	input  wire logic               clk,
	input  wire kdl_pkg::cell_ctrl_t ctrl,
	input  wire kdl_pkg::rec_t      new_rec,
	input  wire kdl_pkg::rec_t      prev_rec,
	input  wire kdl_pkg::rec_t      next_rec,
	output kdl_pkg::rec_t           rec
);
	import kdl_pkg::*;

	rec_t rec_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			rec_q <= new_rec;
		end else if (ctrl.push) begin
			rec_q <= prev_rec;
		end else if (ctrl.rotate) begin
			rec_q <= next_rec;
		end
	end

	assign rec = rec_q;

endmodule

`default_nettype wire

[rtl/core/keyed_deque_lookup.sv]
// Top level of the keyed deque lookup block: request/response handshake,
// scan control and the row of kdl_cell storage cells. Depends on kdl_pkg.
`default_nettype none

// Records are held in order in a row of DEPTH cells, the front in cell 0.
// An append loads the cell just behind the last entry and a prepend shifts
// the whole row one place back while cell 0 takes the new record; both, as
// well as dropped inserts and unused commands, are answered without a scan.
// A lookup rotates the row once around through cell 0, where a single key
// comparator sits, so that the row ends in its original order; the first
// match nearest the front wins. One request is in work at a time, and a new
// request is not taken while the previous response is held by rsp_stall.
// No clearing is needed after reset.
module keyed_deque_lookup (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire kdl_pkg::req_t req_data,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output kdl_pkg::rsp_t      rsp_data
);
	import kdl_pkg::*;

	rec_t cell_rec [DEPTH];
	cell_ctrl_t cell_ctrl [DEPTH];
	rec_t new_rec;

	logic [CNT_W-1:0] count_q;
	logic busy_q;
	logic [IDX_W-1:0] step_q;
	logic found_q;
	logic signed [15:0] hit_height_q;
	logic [4:0] key_day_q;
	logic [3:0] key_month_q;
	logic [11:0] key_year_q;
	logic [4:0] key_hour_q;
	logic rsp_valid_q;
	rsp_t rsp_q;

	logic accept;
	logic full;
	logic is_insert;
	logic do_append;
	logic do_prepend;
	logic scan_hit;
	logic scan_last;
	logic rsp_load;

	assign req_stall = busy_q || (rsp_valid_q && rsp_stall);
	assign accept = req_valid && !req_stall;
	assign full = (count_q == CNT_W'(DEPTH));
	assign is_insert = (req_data.cmd == CMD_APPEND) || (req_data.cmd == CMD_PREPEND);
	assign do_append = accept && (req_data.cmd == CMD_APPEND) && !full;
	assign do_prepend = accept && (req_data.cmd == CMD_PREPEND) && !full;

	assign new_rec = '{day: req_data.day, month: req_data.month, year: req_data.year,
		hour: req_data.hour, height: req_data.height_in};

	// Only positions below the entry count take part in the match.
	assign scan_hit = busy_q && !found_q && (CNT_W'(step_q) < count_q)
		&& (cell_rec[0].day == key_day_q) && (cell_rec[0].month == key_month_q)
		&& (cell_rec[0].year == key_year_q) && (cell_rec[0].hour == key_hour_q);
	assign scan_last = busy_q && (step_q == IDX_W'(DEPTH - 1));
	assign rsp_load = (accept && (req_data.cmd != CMD_LOOKUP)) || scan_last;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		assign cell_ctrl[i].load = do_append && (count_q == CNT_W'(i));
		assign cell_ctrl[i].push = do_prepend;
		assign cell_ctrl[i].rotate = busy_q;

		kdl_cell u_cell (
			.clk      (clk),
			.ctrl     (cell_ctrl[i]),
			.new_rec  (new_rec),
			.prev_rec ((i == 0) ? new_rec : cell_rec[(i + DEPTH - 1) % DEPTH]),
			.next_rec (cell_rec[(i + 1) % DEPTH]),
			.rec      (cell_rec[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			busy_q <= 1'b0;
			step_q <= '0;
			found_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (do_append || do_prepend) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (accept) begin
				if (req_data.cmd == CMD_LOOKUP) begin
					busy_q <= 1'b1;
					step_q <= '0;
					found_q <= 1'b0;
				end
			end
			if (busy_q) begin
				step_q <= step_q + IDX_W'(1);
				if (scan_hit) begin
					found_q <= 1'b1;
				end
				if (scan_last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_day_q <= req_data.day;
			key_month_q <= req_data.month;
			key_year_q <= req_data.year;
			key_hour_q <= req_data.hour;
			if (req_data.cmd != CMD_LOOKUP) begin
				rsp_q.found <= 1'b0;
				rsp_q.height_out <= '0;
				rsp_q.overflow <= is_insert && full;
				if (do_append || do_prepend) begin
					rsp_q.entry_count <= COUNT_OUT_W'(count_q + CNT_W'(1));
				end else begin
					rsp_q.entry_count <= COUNT_OUT_W'(count_q);
				end
			end
		end
		if (scan_hit) begin
			hit_height_q <= cell_rec[0].height;
		end
		if (scan_last) begin
			rsp_q.found <= found_q || scan_hit;
			rsp_q.overflow <= 1'b0;
			rsp_q.entry_count <= COUNT_OUT_W'(count_q);
			if (found_q) begin
				rsp_q.height_out <= hit_height_q;
			end else if (scan_hit) begin
				rsp_q.height_out <= cell_rec[0].height;
			end else begin
				rsp_q.height_out <= NOT_FOUND_HEIGHT;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data = rsp_q;

endmodule

`default_nettype wire

[verif/keyed_deque_lookup_tb.sv]
// Self-checking testbench for keyed_deque_lookup: drives appends, prepends and keyed lookups
// with random pacing on both handshakes and checks every response against a deque predictor.
// Depends on kdl_pkg and the keyed_deque_lookup RTL.
module keyed_deque_lookup_tb;
	import kdl_pkg::*;

	localparam int CLK_HALF = 2;
	localparam int RESET_CYCLES = 12;
	localparam int RANDOM_ITEMS = 1430;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int TAIL_CYCLES = DEPTH + 16;
	localparam int MAX_REPORTS = 40;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	// Holds the expected contents of the deque and the responses still owed by the block.
	class deque_scoreboard;
		rec_t rows[$];
		rsp_t owed[$];
		int errors;
		int lookups;
		int hits;
		int inserts;
		int dropped;
		int unused;

		function void note_request(req_t r);
			rsp_t e;
			rec_t rec;
			e = '0;
			rec.day = r.day;
			rec.month = r.month;
			rec.year = r.year;
			rec.hour = r.hour;
			rec.height = r.height_in;
			case (r.cmd)
				CMD_APPEND, CMD_PREPEND: begin
					inserts++;
					if (rows.size() >= DEPTH) begin
						e.overflow = 1'b1;
						dropped++;
					end else if (r.cmd == CMD_APPEND) begin
						rows.push_back(rec);
					end else begin
						rows.push_front(rec);
					end
				end
				CMD_LOOKUP: begin
					lookups++;
					e.height_out = NOT_FOUND_HEIGHT;
					// The entry nearest the front wins when keys repeat.
					for (int i = 0; i < rows.size(); i++) begin
						if (rows[i].day == r.day && rows[i].month == r.month &&
								rows[i].year == r.year && rows[i].hour == r.hour) begin
							e.found = 1'b1;
							e.height_out = rows[i].height;
							hits++;
							break;
						end
					end
				end
				default: begin
					unused++;
				end
			endcase
			e.entry_count = COUNT_OUT_W'(rows.size());
			owed.push_back(e);
		endfunction

		function void report(string field, int want, int got);
			errors++;
			if (errors <= MAX_REPORTS) begin
				$display("%0t: %s mismatch, expected %0d got %0d", $time, field, want, got);
			end
		endfunction

		function void check_response(rsp_t got);
			rsp_t want;
			if (owed.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS) begin
					$display("%0t: response with no request outstanding, expected none got %h",
						$time, got);
				end
				return;
			end
			want = owed.pop_front();
			if (got.found !== want.found) report("found", want.found, got.found);
			if (got.height_out !== want.height_out) begin
				report("height_out", int'(want.height_out), int'(got.height_out));
			end
			if (got.entry_count !== want.entry_count) begin
				report("entry_count", want.entry_count, got.entry_count);
			end
			if (got.overflow !== want.overflow) report("overflow", want.overflow, got.overflow);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req_data;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp_data;

	deque_scoreboard sb = new();
	logic [25:0] key_pool[$];
	bit hold_off_req = 1'b0;
	bit gappy = 1'b0;
	int burst_left = 1;
	int quiet_cycles = 0;

	keyed_deque_lookup u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data(req_data),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_data(rsp_data)
	);

	always #(CLK_HALF) clk = ~clk;

	// Both channels are sampled here, at the rising edge, before any state moves.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) sb.check_response(rsp_data);
			if (req_valid && !req_stall) sb.note_request(req_data);
			if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= WATCHDOG_LIMIT) begin
					$display("%0t: nothing accepted for %0d cycles", $time, WATCHDOG_LIMIT);
					$display("keyed_deque_lookup_tb: FAIL");
					$finish;
				end
			end
		end
	end

	// Response side: stretches of steady, light or heavy stalling, plus long hold-offs.
	initial begin
		int mode;
		int span;
		rsp_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 2);
			span = $urandom_range(20, 300);
			repeat (span) begin
				@(negedge clk);
				if (hold_off_req) begin
					rsp_stall = 1'b1;
					repeat (HOLD_OFF_CYCLES) @(negedge clk);
					hold_off_req = 1'b0;
				end
				case (mode)
					0: rsp_stall = 1'b0;
					1: rsp_stall = ($urandom_range(0, 3) == 0);
					default: rsp_stall = ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	function automatic req_t make_req(logic [1:0] cmd, int day, int month, int year, int hour,
			int height);
		req_t r;
		r.cmd = cmd;
		r.day = day[4:0];
		r.month = month[3:0];
		r.year = year[11:0];
		r.hour = hour[4:0];
		r.height_in = height[15:0];
		return r;
	endfunction

	// Inserts are 45 percent while there is room and 8 percent when full; most others are lookups of stored keys.
	function automatic req_t pick_request();
		req_t r;
		int roll;
		int sub;
		int ins_pct;
		logic [25:0] key;
		r = make_req(CMD_LOOKUP, $urandom_range(1, 31), $urandom_range(1, 12),
			$urandom_range(0, 4095), $urandom_range(0, 23), $urandom_range(0, 16'hFFFF));
		key = {r.day, r.month, r.year, r.hour};
		roll = $urandom_range(0, 99);
		sub = $urandom_range(0, 9);
		ins_pct = (sb.rows.size() < DEPTH) ? 45 : 8;
		if (sub < 2) key = $urandom_range(0, 26'h3FF_FFFF);
		if (roll < 4) begin
			r.cmd = CMD_UNUSED;
		end else if (roll < 4 + ins_pct) begin
			r.cmd = ($urandom_range(0, 1) != 0) ? CMD_APPEND : CMD_PREPEND;
			if (sub >= 8 && key_pool.size() != 0) begin
				key = key_pool[$urandom_range(0, key_pool.size() - 1)];
			end
			key_pool.push_back(key);
		end else if (key_pool.size() != 0 && sub >= 2) begin
			key = key_pool[$urandom_range(0, key_pool.size() - 1)];
			if (sub == 2) key = key ^ (26'd1 << $urandom_range(0, 25));
		end
		{r.day, r.month, r.year, r.hour} = key;
		return r;
	endfunction

	task automatic send_request(req_t r);
		req_data = r;
		req_valid = 1'b1;
		do @(posedge clk); while (req_stall);
		@(negedge clk);
	endtask

	task automatic pace();
		if (gappy) begin
			burst_left--;
			if (burst_left <= 0) begin
				req_valid = 1'b0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
				burst_left = $urandom_range(1, 16);
			end
		end
	endtask

	initial begin
		req_t directed[$];
		req_t item;
		int sent;
		int offered;
		bit [1:0] pressed;
		sent = 0;
		offered = 0;
		pressed = 2'b00;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_data = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		directed.push_back(make_req(CMD_LOOKUP, 5, 6, 2000, 7, 0));
		directed.push_back(make_req(CMD_UNUSED, 9, 9, 9, 9, 9));
		directed.push_back(make_req(CMD_APPEND, 31, 15, 4095, 31, 16'h7FFF));
		directed.push_back(make_req(CMD_PREPEND, 0, 0, 0, 0, 16'h8000));
		directed.push_back(make_req(CMD_APPEND, 1, 1, 0, 0, 0));
		directed.push_back(make_req(CMD_PREPEND, 31, 12, 4095, 23, 16'hFFFF));
		directed.push_back(make_req(CMD_LOOKUP, 31, 15, 4095, 31, 16'h1111));
		directed.push_back(make_req(CMD_LOOKUP, 0, 0, 0, 0, 0));
		directed.push_back(make_req(CMD_LOOKUP, 31, 12, 4095, 23, 16'hFFFF));
		directed.push_back(make_req(CMD_LOOKUP, 1, 1, 0, 0, 0));
		// Same key again: the copy behind must not win, the copy in front must.
		directed.push_back(make_req(CMD_APPEND, 1, 1, 0, 0, 16'h1234));
		directed.push_back(make_req(CMD_LOOKUP, 1, 1, 0, 0, 0));
		directed.push_back(make_req(CMD_PREPEND, 1, 1, 0, 0, -5));
		directed.push_back(make_req(CMD_LOOKUP, 1, 1, 0, 0, 16'h7FFF));
		directed.push_back(make_req(CMD_LOOKUP, 1, 1, 0, 1, 0));
		directed.push_back(make_req(CMD_UNUSED, 31, 15, 4095, 31, 16'hFFFF));
		directed.push_back(make_req(CMD_LOOKUP, 12, 3, 1999, 22, 0));
		foreach (directed[i]) begin
			send_request(directed[i]);
			pace();
		end
		key_pool.push_back({5'd1, 4'd1, 12'd0, 5'd0});
		key_pool.push_back({5'd31, 4'd12, 12'd4095, 5'd23});

		while (sent < RANDOM_ITEMS) begin
			if (offered % 100 == 0) begin
				gappy = ($urandom_range(0, 2) != 0);
				burst_left = $urandom_range(1, 16);
			end
			// Long response hold-offs while requests keep coming, so the input backs up.
			if (sent >= 300 && !pressed[0]) begin
				pressed[0] = 1'b1;
				hold_off_req = 1'b1;
			end
			if (sent >= 1000 && !pressed[1]) begin
				pressed[1] = 1'b1;
				hold_off_req = 1'b1;
			end
			item = pick_request();
			send_request(item);
			offered++;
			if (item.cmd != CMD_UNUSED) sent++;
			pace();
		end
		req_valid = 1'b0;

		while (sb.owed.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Run covered %0d inserts (%0d dropped on a full store) and %0d lookups",
			sb.inserts, sb.dropped, sb.lookups);
		$display("with %0d hits, plus %0d unused commands; %0d mismatches.",
			sb.hits, sb.unused, sb.errors);
		if (sb.errors == 0 && sb.owed.size() == 0) begin
			$display("keyed_deque_lookup_tb: PASS");
		end else begin
			$display("keyed_deque_lookup_tb: FAIL");
		end
		$finish;
	end
endmodule

[keyed_deque_lookup.f]
rtl/core/kdl_pkg.sv
rtl/core/kdl_cell.sv
rtl/core/keyed_deque_lookup.sv
verif/keyed_deque_lookup_tb.sv
